[design/bma_pkg.sv]
package bma_pkg;

	localparam int unsigned NUM_PAGES_DEF = 8;
	localparam int unsigned PAGE_BITS_DEF = 64;

	// buckets handled by the shared run unit per cycle
	localparam int unsigned CHUNK     = 8;
	localparam int unsigned CHUNK_LOG = 3;

	// internal bucket index / count width, covers the largest arena (64 x 64)
	localparam int unsigned IW = 13;

	localparam int unsigned REQ_W  = 2;
	localparam int unsigned WID_W  = 10;
	localparam int unsigned IDX_W  = 9;
	localparam int unsigned STAT_W = 2;

	localparam int unsigned CFG_AW = 3;
	localparam int unsigned CFG_DW = 32;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MARK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SWEEP = 2'd2;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SKIP  = 2'd2;

	localparam logic [CFG_AW-1:0] ADDR_FIT_MODE = 3'd0;

	typedef struct packed {
		logic [IW-1:0] run;
		logic [IW-1:0] run_at;
		logic          have;
		logic [IW-1:0] best_len;
		logic [IW-1:0] best_at;
		logic          found;
		logic [IW-1:0] found_at;
	} run_state_t;

endpackage

[design/bma_if.sv]
interface bma_req_if import bma_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [WID_W-1:0]  alloc_width;
	logic [IDX_W-1:0]  bucket_index;

	modport source (output valid, req_type, alloc_width, bucket_index, input ready);
	modport sink   (input valid, req_type, alloc_width, bucket_index, output ready);
endinterface

interface bma_rsp_if import bma_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  start_index;
	logic [IDX_W-1:0]  end_index;
	logic              is_allocated;
	logic              arena_empty;

	modport source (output valid, status, start_index, end_index, is_allocated,
		arena_empty, input ready);
	modport sink   (input valid, status, start_index, end_index, is_allocated,
		arena_empty, output ready);
endinterface

[design/bma_cfg.sv]
module bma_cfg import bma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output logic              fit_mode
);
	logic fit_mode_q;

	assign pready   = 1'b1;
	assign fit_mode = fit_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == ADDR_FIT_MODE) begin
			fit_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_FIT_MODE) begin
			prdata[0] = fit_mode_q;
		end
	end
endmodule

[design/bma_run_unit.sv]
module bma_run_unit import bma_pkg::*; (
	input  logic             mode,
	input  logic [IW-1:0]    width,
	input  logic [IW-1:0]    base,
	input  logic [CHUNK-1:0] busy,
	input  run_state_t       cur,
	output run_state_t       nxt
);
	run_state_t s;

	// Track the free run across one chunk; first fit freezes once found.
	always_comb begin
		s = cur;
		for (int j = 0; j < CHUNK; j++) begin
			if (!s.found) begin
				if (!busy[j]) begin
					if (s.run == '0) begin
						s.run_at = base + IW'(j);
					end
					s.run = s.run + 1'b1;
					if (!mode && s.run == width) begin
						s.found    = 1'b1;
						s.found_at = s.run_at;
					end
				end else begin
					if (mode && s.run >= width && (!s.have || s.run < s.best_len)) begin
						s.have     = 1'b1;
						s.best_len = s.run;
						s.best_at  = s.run_at;
					end
					s.run = '0;
				end
			end
		end
		nxt = s;
	end
endmodule

[design/bitmap_allocator_mark_sweep_core.sv]
// Bitmap bucket allocator with mark and sweep. The arena of NUM_PAGES x PAGE_BITS buckets is
// tracked by four flat bitmaps (allocated, object start, object end, mark). One request is
// taken at a time; in_ch.ready is high only while the sequencer is idle. Steps per request,
// with C = ceil(buckets / 8) chunks (512 buckets: C = 64):
//   allocate : S_EXEC, an S_SCAN pass over up to C chunks, S_FLUSH, S_SET on each chunk
//              the run touches, S_OUT; first fit stops scanning at the first fit.
//   mark     : S_EXEC, S_BACK back to the object start, S_FWD forward to its end, S_OUT.
//   sweep    : S_EXEC, S_SWEEP over all C chunks, S_OUT.   query : S_EXEC, S_OUT.
// One shared run unit examines eight buckets a cycle during the search; the mark walk moves one
// bucket a cycle. Results sit in an output register, so a finished beat may wait for out_ch.ready
// without losing data. fit_mode (byte address 0) selects first fit (0) or best fit (1); write
// it only while no request is in flight.
module bitmap_allocator_mark_sweep_core import bma_pkg::*; #(
	parameter int unsigned NUM_PAGES = NUM_PAGES_DEF,
	parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	bma_req_if.sink           in_ch,
	bma_rsp_if.source         out_ch
);
	localparam int unsigned NBKT    = NUM_PAGES * PAGE_BITS;
	localparam int unsigned NCH_RAW = (NBKT + CHUNK - 1) / CHUNK;
	localparam int unsigned NCH     = (NCH_RAW < 2) ? 2 : NCH_RAW;
	localparam int unsigned CW      = $clog2(NCH);
	localparam int unsigned NB      = NCH * CHUNK;
	localparam int unsigned BW      = CW + CHUNK_LOG;

	localparam logic [IW-1:0] ARENA = IW'(NBKT);
	localparam logic [CW-1:0] LAST_CH = CW'(NCH - 1);

	localparam int unsigned ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] S_EXEC  = 4'd1;
	localparam logic [ST_W-1:0] S_SCAN  = 4'd2;
	localparam logic [ST_W-1:0] S_FLUSH = 4'd3;
	localparam logic [ST_W-1:0] S_SET   = 4'd4;
	localparam logic [ST_W-1:0] S_BACK  = 4'd5;
	localparam logic [ST_W-1:0] S_FWD   = 4'd6;
	localparam logic [ST_W-1:0] S_SWEEP = 4'd7;
	localparam logic [ST_W-1:0] S_OUT   = 4'd8;

	logic fit_mode;

	// bitmaps, padded to whole chunks; pad bits are never set
	logic [NB-1:0] alloc_q, start_q, end_q, live_q;

	logic [ST_W-1:0]   state_q;
	logic [REQ_W-1:0]  req_q;
	logic [WID_W-1:0]  width_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CW-1:0]     pos_q;
	run_state_t        rs_q, rs_nxt;
	logic [IW-1:0]     at_q, lo_q, hi_q;
	logic              empty_acc_q;

	// pending result fields, copied into the output register in S_OUT
	logic [STAT_W-1:0] p_status_q;
	logic [IW-1:0]     p_start_q, p_end_q;
	logic              p_alloc_q, p_empty_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] o_status_q;
	logic [IDX_W-1:0]  o_start_q, o_end_q;
	logic              o_alloc_q, o_empty_q;

	logic [IW-1:0]     width_ext, idx_ext, last_w, lo_m1, hi_p1;
	logic [BW-1:0]     base_b;
	logic [CHUNK-1:0]  busy, set_mask;
	logic [CHUNK-1:0]  live_ch;
	logic              idx_in;
	logic [CW-1:0]     at_ch, last_ch;

	bma_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.fit_mode(fit_mode)
	);

	assign width_ext = IW'(width_q);
	assign idx_ext   = IW'(idx_q);
	assign idx_in    = idx_ext < ARENA;
	assign last_w    = at_q + width_ext - 1'b1;
	assign lo_m1     = lo_q - 1'b1;
	assign hi_p1     = hi_q + 1'b1;
	assign base_b    = {pos_q, {CHUNK_LOG{1'b0}}};
	assign at_ch     = CW'(at_q >> CHUNK_LOG);
	assign last_ch   = CW'(last_w >> CHUNK_LOG);
	assign live_ch   = live_q[base_b +: CHUNK];

	// Busy and reserve masks for the current chunk; buckets past the arena count as busy.
	always_comb begin
		for (int j = 0; j < CHUNK; j++) begin
			busy[j] = (state_q == S_FLUSH) || (IW'(base_b) + IW'(j) >= ARENA) ||
				alloc_q[base_b + BW'(j)];
			set_mask[j] = (IW'(base_b) + IW'(j) >= at_q) && (IW'(base_b) + IW'(j) <= last_w);
		end
	end

	bma_run_unit u_run (
		.mode (fit_mode),
		.width(width_ext),
		.base (IW'(base_b)),
		.busy (busy),
		.cur  (rs_q),
		.nxt  (rs_nxt)
	);

	assign in_ch.ready         = (state_q == S_IDLE);
	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = o_status_q;
	assign out_ch.start_index  = o_start_q;
	assign out_ch.end_index    = o_end_q;
	assign out_ch.is_allocated = o_alloc_q;
	assign out_ch.arena_empty  = o_empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alloc_q     <= '0;
			start_q     <= '0;
			end_q       <= '0;
			live_q      <= '0;
			req_q       <= REQ_ALLOC;
			width_q     <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			rs_q        <= '0;
			at_q        <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			empty_acc_q <= 1'b0;
			p_status_q  <= STAT_DONE;
			p_start_q   <= '0;
			p_end_q     <= '0;
			p_alloc_q   <= 1'b0;
			p_empty_q   <= 1'b0;
			out_valid_q <= 1'b0;
			o_status_q  <= STAT_DONE;
			o_start_q   <= '0;
			o_end_q     <= '0;
			o_alloc_q   <= 1'b0;
			o_empty_q   <= 1'b0;
		end else begin
			// drop the beat once the sink takes it; S_OUT reloads the register itself
			if (out_valid_q && out_ch.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						req_q      <= in_ch.req_type;
						width_q    <= in_ch.alloc_width;
						idx_q      <= in_ch.bucket_index;
						p_status_q <= STAT_DONE;
						p_start_q  <= '0;
						p_end_q    <= '0;
						p_alloc_q  <= 1'b0;
						p_empty_q  <= 1'b0;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (req_q)
						REQ_ALLOC: begin
							if (width_q == '0 || width_ext > ARENA) begin
								p_status_q <= STAT_NOFIT;
								state_q    <= S_OUT;
							end else begin
								pos_q   <= '0;
								rs_q    <= '0;
								state_q <= S_SCAN;
							end
						end
						REQ_MARK: begin
							if (!idx_in || !alloc_q[idx_ext[BW-1:0]] ||
								live_q[idx_ext[BW-1:0]]) begin
								p_status_q <= STAT_SKIP;
								state_q    <= S_OUT;
							end else begin
								live_q[idx_ext[BW-1:0]] <= 1'b1;
								lo_q    <= idx_ext;
								state_q <= S_BACK;
							end
						end
						REQ_SWEEP: begin
							pos_q       <= '0;
							empty_acc_q <= 1'b1;
							state_q     <= S_SWEEP;
						end
						default: begin
							p_alloc_q <= idx_in && alloc_q[idx_ext[BW-1:0]];
							state_q   <= S_OUT;
						end
					endcase
				end
				S_SCAN: begin
					rs_q <= rs_nxt;
					if (rs_nxt.found) begin
						at_q    <= rs_nxt.found_at;
						pos_q   <= CW'(rs_nxt.found_at >> CHUNK_LOG);
						state_q <= S_SET;
					end else if (pos_q == LAST_CH) begin
						state_q <= S_FLUSH;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_FLUSH: begin
					// close a run that reaches the arena end
					if (rs_nxt.have) begin
						at_q    <= rs_nxt.best_at;
						pos_q   <= CW'(rs_nxt.best_at >> CHUNK_LOG);
						state_q <= S_SET;
					end else begin
						p_status_q <= STAT_NOFIT;
						state_q    <= S_OUT;
					end
				end
				S_SET: begin
					alloc_q[base_b +: CHUNK] <= alloc_q[base_b +: CHUNK] | set_mask;
					if (pos_q == at_ch) begin
						start_q[at_q[BW-1:0]] <= 1'b1;
					end
					if (pos_q == last_ch) begin
						end_q[last_w[BW-1:0]] <= 1'b1;
						p_start_q <= at_q;
						p_end_q   <= last_w;
						state_q   <= S_OUT;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_BACK: begin
					if (start_q[lo_q[BW-1:0]] || lo_q == '0) begin
						hi_q    <= idx_ext;
						state_q <= S_FWD;
					end else begin
						lo_q                  <= lo_m1;
						live_q[lo_m1[BW-1:0]] <= 1'b1;
					end
				end
				S_FWD: begin
					if (end_q[hi_q[BW-1:0]] || hi_p1 >= ARENA) begin
						p_start_q <= lo_q;
						p_end_q   <= hi_q;
						state_q   <= S_OUT;
					end else begin
						hi_q                  <= hi_p1;
						live_q[hi_p1[BW-1:0]] <= 1'b1;
					end
				end
				S_SWEEP: begin
					start_q[base_b +: CHUNK] <= start_q[base_b +: CHUNK] & live_ch;
					end_q[base_b +: CHUNK]   <= end_q[base_b +: CHUNK] & live_ch;
					alloc_q[base_b +: CHUNK] <= live_ch;
					live_q[base_b +: CHUNK]  <= '0;
					if (live_ch != '0) begin
						empty_acc_q <= 1'b0;
					end
					if (pos_q == LAST_CH) begin
						p_empty_q <= empty_acc_q && (live_ch == '0);
						state_q   <= S_OUT;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						o_status_q  <= p_status_q;
						o_start_q   <= IDX_W'(p_start_q);
						o_end_q     <= IDX_W'(p_end_q);
						o_alloc_q   <= p_alloc_q;
						o_empty_q   <= p_empty_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
